[rtl/core/dpec_pkg.sv]
package dpec_pkg;

	// field widths
	localparam int POS_W  = 20;
	localparam int VEL_W  = 20;
	localparam int DIA_W  = 16;
	localparam int MASS_W = 16;

	// internal widths
	localparam int DIFF_W  = POS_W + 1;              // centre and velocity differences
	localparam int SQ_W    = 2 * DIFF_W;             // one signed product of differences
	localparam int SUM_W   = DIA_W + 1;              // diameter sum
	localparam int MSUM_W  = MASS_W + 1;             // mass sum, also twice one mass
	localparam int DC_W    = 16;                     // |dx|, |dy| bound under overlap
	localparam int DIST2_W = 32;                     // squared distance bound under overlap
	localparam int DOT_W   = 38;                     // |dot| bound under overlap
	localparam int PROD_W  = DOT_W + DC_W;
	localparam int NUM_W   = PROD_W + MSUM_W;
	localparam int DEN_W   = DIST2_W + MSUM_W;
	localparam int QB      = 23;                     // quotient bits, one per divider stage
	localparam int REM_W   = DEN_W + 1;
	localparam int CORR_W  = QB + 1;
	localparam int ACC_W   = CORR_W + 2;             // velocity plus correction
	localparam int LANES   = 4;

	// lane order of the four corrections
	localparam int LANE_1X = 0;
	localparam int LANE_1Y = 1;
	localparam int LANE_2X = 2;
	localparam int LANE_2Y = 3;

	// one division lane: partial remainder and numerator bits turning into quotient bits
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QB-1:0]    low;
	} lane_t;

	// side data that travels with the divider lanes
	typedef struct packed {
		logic                    hit;
		logic                    sx;
		logic                    sy;
		logic [DEN_W-1:0]        den;
		logic signed [VEL_W-1:0] v1x;
		logic signed [VEL_W-1:0] v1y;
		logic signed [VEL_W-1:0] v2x;
		logic signed [VEL_W-1:0] v2y;
	} side_t;

	// clamp a wide sum to the velocity range
	function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'({1'b0, {(VEL_W-1){1'b1}}});
		lo = -hi - ACC_W'(1);
		if (v > hi) begin
			return VEL_W'(hi);
		end else if (v < lo) begin
			return VEL_W'(lo);
		end
		return VEL_W'(v);
	endfunction

endpackage

[rtl/core/dpec_pair_if.sv]
interface dpec_pair_if;
	import dpec_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [POS_W-1:0]  first_pos_x;
	logic signed [POS_W-1:0]  first_pos_y;
	logic signed [VEL_W-1:0]  first_vel_x;
	logic signed [VEL_W-1:0]  first_vel_y;
	logic [DIA_W-1:0]         first_diameter;
	logic [MASS_W-1:0]        first_mass;
	logic signed [POS_W-1:0]  second_pos_x;
	logic signed [POS_W-1:0]  second_pos_y;
	logic signed [VEL_W-1:0]  second_vel_x;
	logic signed [VEL_W-1:0]  second_vel_y;
	logic [DIA_W-1:0]         second_diameter;
	logic [MASS_W-1:0]        second_mass;

	modport source (
		output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_diameter,
		first_mass, second_pos_x, second_pos_y, second_vel_x, second_vel_y,
		second_diameter, second_mass,
		input  ready
	);
	modport sink (
		input  valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_diameter,
		first_mass, second_pos_x, second_pos_y, second_vel_x, second_vel_y,
		second_diameter, second_mass,
		output ready
	);

endinterface

[rtl/core/dpec_vel_if.sv]
interface dpec_vel_if;
	import dpec_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    impact;
	logic signed [VEL_W-1:0] new_first_vel_x;
	logic signed [VEL_W-1:0] new_first_vel_y;
	logic signed [VEL_W-1:0] new_second_vel_x;
	logic signed [VEL_W-1:0] new_second_vel_y;

	modport source (
		output valid, impact, new_first_vel_x, new_first_vel_y, new_second_vel_x,
		new_second_vel_y,
		input  ready
	);
	modport sink (
		input  valid, impact, new_first_vel_x, new_first_vel_y, new_second_vel_x,
		new_second_vel_y,
		output ready
	);

endinterface

[rtl/core/disc_pair_elastic_collision.sv]
// channel     | dir | payload
// pair        | in  | two discs: centre, velocity, diameter, mass
// velocities  | out | impact flag, both new velocities
//
// one pair enters per cycle unless a held result stalls the pipeline; each result passes
// through 5 arithmetic stages, the restoring divider of 23 one-bit stages and the output stage
// arst_n clears all valid bits; payload registers are not reset
// a held result stalls the whole pipeline in place, nothing is dropped or repeated
module disc_pair_elastic_collision (
	input logic        clk,
	input logic        arst_n,
	dpec_pair_if.sink  pair,
	dpec_vel_if.source velocities
);
	import dpec_pkg::*;

	logic en;

	// stage 1 registers
	logic                     vld_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [SUM_W-1:0]         sum_s1;
	logic [MASS_W-1:0]        m1_s1, m2_s1;
	logic signed [VEL_W-1:0]  v1x_s1, v1y_s1, v2x_s1, v2y_s1;

	// stage 2 registers
	logic                     vld_s2;
	logic signed [SQ_W-1:0]   sqx_s2, sqy_s2, pdx_s2, pdy_s2;
	logic [2*SUM_W-1:0]       sumsq_s2;
	logic signed [DIFF_W-1:0] dx_s2, dy_s2;
	logic [MASS_W-1:0]        m1_s2, m2_s2;
	logic [MSUM_W-1:0]        msum_s2;
	logic signed [VEL_W-1:0]  v1x_s2, v1y_s2, v2x_s2, v2y_s2;

	// stage 3 registers
	logic                     vld_s3;
	logic                     hit_s3, sx_s3, sy_s3;
	logic [DIST2_W-1:0]       dist2_s3;
	logic [DOT_W-1:0]         dotmag_s3;
	logic [DC_W-1:0]          adx_s3, ady_s3;
	logic [MASS_W-1:0]        m1_s3, m2_s3;
	logic [MSUM_W-1:0]        msum_s3;
	logic signed [VEL_W-1:0]  v1x_s3, v1y_s3, v2x_s3, v2y_s3;

	// stage 4 registers
	logic                     vld_s4;
	logic [PROD_W-1:0]        px_s4, py_s4;
	logic [MASS_W-1:0]        m1_s4, m2_s4;
	side_t                    side_s4;

	// stage 5 registers
	logic                     vld_s5;
	logic [NUM_W-1:0]         num_s5 [LANES];
	side_t                    side_s5;

	// divider stage registers
	logic                     vld_sd  [QB];
	lane_t                    lane_sd [QB][LANES];
	side_t                    side_sd [QB];

	// output stage
	logic                     vld_s6;

	assign en = !vld_s6 || velocities.ready;
	assign pair.ready = en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pair.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_sd[QB-1];
		end
	end

	// stage 1: differences, diameter sum, zero mass taken as one
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= DIFF_W'(pair.second_pos_x) - DIFF_W'(pair.first_pos_x);
			dy_s1  <= DIFF_W'(pair.second_pos_y) - DIFF_W'(pair.first_pos_y);
			dvx_s1 <= DIFF_W'(pair.second_vel_x) - DIFF_W'(pair.first_vel_x);
			dvy_s1 <= DIFF_W'(pair.second_vel_y) - DIFF_W'(pair.first_vel_y);
			sum_s1 <= SUM_W'(pair.first_diameter) + SUM_W'(pair.second_diameter);
			m1_s1  <= (pair.first_mass == '0) ? MASS_W'(1) : pair.first_mass;
			m2_s1  <= (pair.second_mass == '0) ? MASS_W'(1) : pair.second_mass;
			v1x_s1 <= pair.first_vel_x;
			v1y_s1 <= pair.first_vel_y;
			v2x_s1 <= pair.second_vel_x;
			v2y_s1 <= pair.second_vel_y;
		end
	end

	// stage 2: squares, dot product terms and mass sum
	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2   <= dx_s1 * dx_s1;
			sqy_s2   <= dy_s1 * dy_s1;
			pdx_s2   <= dvx_s1 * dx_s1;
			pdy_s2   <= dvy_s1 * dy_s1;
			sumsq_s2 <= sum_s1 * sum_s1;
			dx_s2    <= dx_s1;
			dy_s2    <= dy_s1;
			m1_s2    <= m1_s1;
			m2_s2    <= m2_s1;
			msum_s2  <= MSUM_W'(m1_s1) + MSUM_W'(m2_s1);
			v1x_s2   <= v1x_s1;
			v1y_s2   <= v1y_s1;
			v2x_s2   <= v2x_s1;
			v2y_s2   <= v2y_s1;
		end
	end

	// stage 3: overlap and approach test
	logic [SQ_W:0]            dist2;
	logic [SQ_W+2:0]          dist2_x4;
	logic [SQ_W+2:0]          sumsq_ext;
	logic signed [SQ_W:0]     dot;
	logic signed [SQ_W:0]     dot_neg;
	logic signed [DIFF_W-1:0] adx, ady;

	always_comb begin
		dist2     = (SQ_W+1)'($unsigned(sqx_s2)) + (SQ_W+1)'($unsigned(sqy_s2));
		dist2_x4  = {dist2, 2'b00};
		sumsq_ext = (SQ_W+3)'(sumsq_s2);
		dot       = (SQ_W+1)'(pdx_s2) + (SQ_W+1)'(pdy_s2);
		dot_neg   = -dot;
		adx       = dx_s2[DIFF_W-1] ? -dx_s2 : dx_s2;
		ady       = dy_s2[DIFF_W-1] ? -dy_s2 : dy_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s3    <= (dist2 != '0) && (dist2_x4 < sumsq_ext) && dot[SQ_W];
			dist2_s3  <= dist2[DIST2_W-1:0];
			dotmag_s3 <= dot_neg[DOT_W-1:0];
			adx_s3    <= adx[DC_W-1:0];
			ady_s3    <= ady[DC_W-1:0];
			sx_s3     <= dx_s2[DIFF_W-1];
			sy_s3     <= dy_s2[DIFF_W-1];
			m1_s3     <= m1_s2;
			m2_s3     <= m2_s2;
			msum_s3   <= msum_s2;
			v1x_s3    <= v1x_s2;
			v1y_s3    <= v1y_s2;
			v2x_s3    <= v2x_s2;
			v2y_s3    <= v2y_s2;
		end
	end

	// stage 4: |dot| times each offset, denominator
	always_ff @(posedge clk) begin
		if (en) begin
			px_s4       <= PROD_W'(dotmag_s3) * PROD_W'(adx_s3);
			py_s4       <= PROD_W'(dotmag_s3) * PROD_W'(ady_s3);
			m1_s4       <= m1_s3;
			m2_s4       <= m2_s3;
			side_s4.hit <= hit_s3;
			side_s4.sx  <= sx_s3;
			side_s4.sy  <= sy_s3;
			side_s4.den <= DEN_W'(dist2_s3) * DEN_W'(msum_s3);
			side_s4.v1x <= v1x_s3;
			side_s4.v1y <= v1y_s3;
			side_s4.v2x <= v2x_s3;
			side_s4.v2y <= v2y_s3;
		end
	end

	// stage 5: numerators with twice the other mass
	logic [MSUM_W-1:0] tm1, tm2;
	assign tm1 = {m1_s4, 1'b0};
	assign tm2 = {m2_s4, 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5[LANE_1X] <= NUM_W'(px_s4) * NUM_W'(tm2);
			num_s5[LANE_1Y] <= NUM_W'(py_s4) * NUM_W'(tm2);
			num_s5[LANE_2X] <= NUM_W'(px_s4) * NUM_W'(tm1);
			num_s5[LANE_2Y] <= NUM_W'(py_s4) * NUM_W'(tm1);
			side_s5         <= side_s4;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < QB; k++) begin : g_div
		lane_t           lane_in [LANES];
		lane_t           lane_nx [LANES];
		side_t           side_in;
		logic            vld_in;
		logic [REM_W:0]  den_ext;

		if (k == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					lane_in[l].rem = REM_W'(num_s5[l][NUM_W-1:QB]);
					lane_in[l].low = num_s5[l][QB-1:0];
				end
			end
			assign side_in = side_s5;
			assign vld_in  = vld_s5;
		end else begin : g_next
			assign lane_in = lane_sd[k-1];
			assign side_in = side_sd[k-1];
			assign vld_in  = vld_sd[k-1];
		end

		assign den_ext = (REM_W+1)'(side_in.den);

		always_comb begin
			logic [REM_W:0] t;
			logic           ge;
			for (int l = 0; l < LANES; l++) begin
				t  = {lane_in[l].rem, lane_in[l].low[QB-1]};
				ge = (t >= den_ext);
				if (ge) begin
					t = t - den_ext;
				end
				lane_nx[l].rem = t[REM_W-1:0];
				lane_nx[l].low = {lane_in[l].low[QB-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k] <= 1'b0;
			end else if (en) begin
				vld_sd[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lane_sd[k] <= lane_nx;
				side_sd[k] <= side_in;
			end
		end
	end

	// output stage: round half away, apply sign, saturate
	side_t                   side_l;
	logic [REM_W:0]          den_l;
	logic signed [ACC_W-1:0] corr [LANES];
	logic signed [VEL_W-1:0] nv1x, nv1y, nv2x, nv2y;

	assign side_l = side_sd[QB-1];
	assign den_l  = (REM_W+1)'(side_l.den);

	always_comb begin
		logic [CORR_W-1:0]       qr;
		logic signed [ACC_W-1:0] mag_c;
		logic                    neg_dc;
		for (int l = 0; l < LANES; l++) begin
			qr     = CORR_W'(lane_sd[QB-1][l].low)
			       + CORR_W'({lane_sd[QB-1][l].rem, 1'b0} >= den_l);
			mag_c  = ACC_W'(qr);
			neg_dc = (l == LANE_1X || l == LANE_2X) ? side_l.sx : side_l.sy;
			// dot is negative, so the correction is positive for a negative offset
			corr[l] = neg_dc ? mag_c : -mag_c;
		end
		nv1x = sat_vel(ACC_W'(side_l.v1x) + corr[LANE_1X]);
		nv1y = sat_vel(ACC_W'(side_l.v1y) + corr[LANE_1Y]);
		nv2x = sat_vel(ACC_W'(side_l.v2x) - corr[LANE_2X]);
		nv2y = sat_vel(ACC_W'(side_l.v2y) - corr[LANE_2Y]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			velocities.impact           <= side_l.hit;
			velocities.new_first_vel_x  <= side_l.hit ? nv1x : side_l.v1x;
			velocities.new_first_vel_y  <= side_l.hit ? nv1y : side_l.v1y;
			velocities.new_second_vel_x <= side_l.hit ? nv2x : side_l.v2x;
			velocities.new_second_vel_y <= side_l.hit ? nv2y : side_l.v2y;
		end
	end

	assign velocities.valid = vld_s6;

endmodule
